[rtl/cst_pkg.sv]
// shared types and byte constants for the csv stream tokenizer
`default_nettype none

package cst_pkg;

  // special byte values
  localparam logic [7:0] QuoteChar  = 8'h22;
  localparam logic [7:0] LfChar     = 8'h0A;
  localparam logic [7:0] CrChar     = 8'h0D;
  localparam logic [7:0] CommaChar  = 8'h2C;

  // one input word after the input register
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } item_t;

  // one result word
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       field_end;
    logic       row_end;
    logic       document_end;
  } result_t;

  // text parsing state carried from byte to byte
  typedef struct packed {
    logic quoting;
    logic quote_pending;
    logic row_has_fields;
    logic field_has_bytes;
  } parse_state_t;

endpackage

`default_nettype wire

[rtl/cst_parse_core.sv]
// per-byte tokenizer decision logic and the text state it keeps
`default_nettype none

module cst_parse_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  cst_pkg::item_t  item_i,
  input  logic [7:0]      separator_i,
  output cst_pkg::result_t result_o
);
  import cst_pkg::*;

  parse_state_t state_q, state_d;

  // decide what this byte does and where the state goes
  always_comb begin
    logic outside;
    logic emit;
    logic [7:0] c;
    c           = item_i.text_byte;
    outside     = 1'b0;
    emit        = 1'b0;
    state_d     = state_q;
    result_o    = '0;

    if (state_q.quote_pending) begin
      state_d.quote_pending = 1'b0;
      if (c == QuoteChar) begin
        emit = 1'b1;
      end else begin
        state_d.quoting = 1'b0;
        outside         = 1'b1;
      end
    end else if (state_q.quoting) begin
      if (c == QuoteChar) begin
        state_d.quote_pending = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end else begin
      outside = 1'b1;
    end

    // bytes handled outside quotes; quote wins over a matching separator
    if (outside) begin
      if (c == QuoteChar) begin
        state_d.quoting = 1'b1;
      end else if (c == separator_i) begin
        result_o.field_end      = 1'b1;
        state_d.row_has_fields  = 1'b1;
        state_d.field_has_bytes = 1'b0;
      end else if (c == LfChar) begin
        if (state_q.row_has_fields || state_q.field_has_bytes) begin
          result_o.field_end      = 1'b1;
          result_o.row_end        = 1'b1;
          state_d.row_has_fields  = 1'b0;
          state_d.field_has_bytes = 1'b0;
        end
      end else if (c == CrChar) begin
        // bare carriage return is dropped
      end else begin
        emit = 1'b1;
      end
    end

    if (emit) begin
      result_o.byte_valid     = 1'b1;
      result_o.byte_value     = c;
      state_d.field_has_bytes = 1'b1;
    end

    // end of text: flush an open row and start over
    if (item_i.final_byte) begin
      if (state_d.row_has_fields || state_d.field_has_bytes) begin
        result_o.field_end = 1'b1;
        result_o.row_end   = 1'b1;
      end
      state_d = '0;
    end
    result_o.document_end = item_i.final_byte;
  end

  // state advances only when a word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cst_out_reg.sv]
// result register between the tokenizer logic and the output stream
`default_nettype none

module cst_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  cst_pkg::result_t result_i,
  output logic             ready_o,
  output logic             valid_o,
  output cst_pkg::result_t result_o,
  input  logic             ready_i
);
  import cst_pkg::*;

  logic    valid_q;
  result_t result_q;

  // loads whenever empty or the current word is taken this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

[rtl/csv_stream_tokenizer.sv]
// top level of the csv stream tokenizer
`default_nettype none

// CSV tokenizer: one text byte in per word, one result word out per byte.
// Each byte passes an input register, the quoting/separator decision logic
// and a result register, so a word is taken every cycle while the output is
// not stalled, and each result leaves from the result register.
// The output carries the data byte in tdata and byte-valid and field/row marks in tuser;
// tlast flags the result of the final text byte, after which the parsing
// state starts fresh. The separator register resets to comma and should be
// written only while no words are in flight.
module csv_stream_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // separator register
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // text input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // final_byte
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] byte_value
  output logic [2:0] m_axis_tuser,   // [0] byte_valid, [1] field_end, [2] row_end
  output logic       m_axis_tlast    // document_end
);
  import cst_pkg::*;

  logic [7:0] separator_q;
  logic       in_valid_q;
  item_t      in_item_q;
  logic       out_ready;
  logic       step;
  result_t    core_result;
  result_t    out_result;

  // separator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      separator_q <= CommaChar;
    end else if (cfg_we_i) begin
      separator_q <= cfg_wdata_i;
    end
  end

  // input register
  assign s_axis_tready = !in_valid_q || out_ready;
  assign step          = in_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.text_byte  <= s_axis_tdata;
      in_item_q.final_byte <= s_axis_tlast;
    end
  end

  cst_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .separator_i (separator_q),
    .result_o    (core_result)
  );

  cst_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .result_i (core_result),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .result_o (out_result),
    .ready_i  (m_axis_tready)
  );

  // pack result word onto the stream
  assign m_axis_tdata = out_result.byte_value;
  assign m_axis_tuser = {out_result.row_end, out_result.field_end, out_result.byte_valid};
  assign m_axis_tlast = out_result.document_end;

endmodule

`default_nettype wire
